/* sv/npt_pkg.sv */
// ----------------------------------------------------------------------------
// npt_pkg
// Shared constants and types of the nearest pose tracker: default field
// widths, multiplier operand codes and the control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package npt_pkg;

  localparam int unsigned NPT_POSITION_BITS   = 24;
  localparam int unsigned NPT_QUATERNION_BITS = 16;

  // Operand fed to the shared squaring unit
  typedef enum logic [2:0] {
    MUL_DX   = 3'd0,
    MUL_DY   = 3'd1,
    MUL_DZ   = 3'd2,
    MUL_BX   = 3'd3,
    MUL_BY   = 3'd4,
    MUL_ROOT = 3'd5
  } mul_src_e;

  // Accumulator operation
  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_e;

  typedef struct packed {
    logic     in_ready;
    logic     load;
    mul_src_e mul_src;
    acc_op_e  acc_op;
    logic     pick;
    logic     root_init;
    logic     root_step;
    logic     emit;
  } npt_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic last;
    logic have_ref;
    logic root_done;
    logic out_busy;
  } npt_stat_t;

endpackage

`default_nettype wire

/* sv/npt_if.sv */
// ----------------------------------------------------------------------------
// npt_in_if / npt_out_if
// Valid/ready channels of the nearest pose tracker: candidate poses in,
// chosen pose with planar error out.
// ----------------------------------------------------------------------------
`default_nettype none

interface npt_in_if #(
  parameter int unsigned PW = 24,
  parameter int unsigned QW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [PW-1:0] pos_x;
  logic signed [PW-1:0] pos_y;
  logic signed [PW-1:0] pos_z;
  logic signed [QW-1:0] quat_x;
  logic signed [QW-1:0] quat_y;
  logic signed [QW-1:0] quat_z;
  logic signed [QW-1:0] quat_w;
  logic                 last_candidate;

  modport source (
    output valid, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w, last_candidate,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w, last_candidate,
    output ready
  );
endinterface

interface npt_out_if #(
  parameter int unsigned PW = 24,
  parameter int unsigned QW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [PW-1:0] out_x;
  logic signed [PW-1:0] out_y;
  logic signed [PW-1:0] out_z;
  logic signed [QW-1:0] out_quat_x;
  logic signed [QW-1:0] out_quat_y;
  logic signed [QW-1:0] out_quat_z;
  logic signed [QW-1:0] out_quat_w;
  logic        [PW-1:0] planar_error;

  modport source (
    output valid, out_x, out_y, out_z, out_quat_x, out_quat_y, out_quat_z, out_quat_w,
           planar_error,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, out_quat_x, out_quat_y, out_quat_z, out_quat_w,
           planar_error,
    output ready
  );
endinterface

`default_nettype wire

/* sv/npt_square.sv */
// ----------------------------------------------------------------------------
// npt_square
// Shared unsigned squaring unit with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module npt_square #(
  parameter int unsigned W = 25
) (
  input  wire logic           clk_i,
  input  wire logic [W-1:0]   a_i,
  output logic      [2*W-1:0] sq_o
);

  logic [2*W-1:0] sq_q;

  always_ff @(posedge clk_i) begin
    sq_q <= a_i * a_i;
  end

  assign sq_o = sq_q;

endmodule

`default_nettype wire

/* sv/npt_ctrl.sv */
// ----------------------------------------------------------------------------
// npt_ctrl
// Sequencer of the tracker: squares the three distances, picks the best
// candidate and runs the bit-by-bit square root at the end of a run.
// ----------------------------------------------------------------------------
`default_nettype none

module npt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire npt_pkg::npt_stat_t stat_i,
  output npt_pkg::npt_ctrl_t     ctrl_o
);
  import npt_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b0000_0000_0001,
    ST_SQ_X     = 12'b0000_0000_0010,
    ST_SQ_Y     = 12'b0000_0000_0100,
    ST_SQ_Z     = 12'b0000_0000_1000,
    ST_ACC      = 12'b0000_0001_0000,
    ST_PICK     = 12'b0000_0010_0000,
    ST_ERR_X    = 12'b0000_0100_0000,
    ST_ERR_Y    = 12'b0000_1000_0000,
    ST_ERR_SUM  = 12'b0001_0000_0000,
    ST_ROOT_MUL = 12'b0010_0000_0000,
    ST_ROOT_CMP = 12'b0100_0000_0000,
    ST_EMIT     = 12'b1000_0000_0000
  } state_e;

  state_e    state_q, state_d;
  npt_ctrl_t ctrl;

  always_comb begin
    state_d        = state_q;
    ctrl           = '0;
    ctrl.mul_src   = MUL_DX;
    ctrl.acc_op    = ACC_HOLD;
    unique case (state_q)
      ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          ctrl.load = 1'b1;
          state_d   = ST_SQ_X;
        end
      end
      ST_SQ_X: begin
        ctrl.mul_src = MUL_DX;
        state_d      = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        ctrl.mul_src = MUL_DY;
        ctrl.acc_op  = ACC_LOAD;
        state_d      = ST_SQ_Z;
      end
      ST_SQ_Z: begin
        ctrl.mul_src = MUL_DZ;
        ctrl.acc_op  = ACC_ADD;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        ctrl.acc_op = ACC_ADD;
        state_d     = ST_PICK;
      end
      ST_PICK: begin
        ctrl.pick = 1'b1;
        if (!stat_i.last) begin
          state_d = ST_IDLE;
        end else if (stat_i.have_ref) begin
          state_d = ST_ERR_X;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_ERR_X: begin
        ctrl.mul_src = MUL_BX;
        state_d      = ST_ERR_Y;
      end
      ST_ERR_Y: begin
        ctrl.mul_src = MUL_BY;
        ctrl.acc_op  = ACC_LOAD;
        state_d      = ST_ERR_SUM;
      end
      ST_ERR_SUM: begin
        ctrl.acc_op    = ACC_ADD;
        ctrl.root_init = 1'b1;
        state_d        = ST_ROOT_MUL;
      end
      ST_ROOT_MUL: begin
        ctrl.mul_src = MUL_ROOT;
        state_d      = ST_ROOT_CMP;
      end
      ST_ROOT_CMP: begin
        ctrl.root_step = 1'b1;
        state_d        = stat_i.root_done ? ST_EMIT : ST_ROOT_MUL;
      end
      ST_EMIT: begin
        if (!stat_i.out_busy) begin
          ctrl.emit = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

`default_nettype wire

/* sv/nearest_pose_tracker.sv */
// ----------------------------------------------------------------------------
// nearest_pose_tracker
// Nearest-neighbor association of candidate poses to the last chosen pose,
// with the planar error of the chosen pose at the end of each run.
// ----------------------------------------------------------------------------
// Candidate poses arrive one beat at a time in runs closed by last_candidate.
// The first run ever yields its first pose with zero error; every later run
// yields the pose nearest (squared 3-D distance, earlier pose wins a tie) to
// the pose chosen before, plus floor(sqrt(x^2 + y^2)) of the chosen position.
// All squaring goes through one registered squaring unit driven by a small
// sequencer; the block takes one candidate at a time. A candidate that does
// not close a run passes through acceptance, three squares, an accumulate
// and the pick before the next ready. The closing candidate of a run also
// squares the chosen x and y, sums them and runs the square root, which
// tries one result bit per multiply and compare through the same squaring
// unit; in the first run ever these steps are skipped. The result sits
// in an output register, so the next candidate is accepted while a finished
// result still waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_pose_tracker #(
  parameter int unsigned POSITION_BITS   = npt_pkg::NPT_POSITION_BITS,
  parameter int unsigned QUATERNION_BITS = npt_pkg::NPT_QUATERNION_BITS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  npt_in_if.sink    cand_i,
  npt_out_if.source pose_o
);
  import npt_pkg::*;

  localparam int unsigned PW     = POSITION_BITS;
  localparam int unsigned QW     = QUATERNION_BITS;
  localparam int unsigned MW     = PW + 1;          // squaring operand width
  localparam int unsigned DIST_W = 2 * PW + 4;      // accumulator width
  localparam int unsigned SAT_W  = (DIST_W > 64) ? 64 : DIST_W;
  localparam int unsigned IDX_W  = $clog2(PW);

  npt_ctrl_t ctrl;
  npt_stat_t stat;

  // Candidate held while it is worked on
  logic signed [PW-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic        [QW-1:0] quat_x_q, quat_y_q, quat_z_q, quat_w_q;
  logic                 last_q;

  // Magnitudes of the distance to the reference, per axis
  logic        [MW-1:0] dx_q, dy_q, dz_q;

  // Reference pose and run state
  logic signed [PW-1:0] ref_x_q, ref_y_q, ref_z_q;
  logic                 have_ref_q;
  logic                 mid_run_q;

  // Best candidate of the current run
  logic        [SAT_W-1:0] best_dist_q;
  logic signed [PW-1:0]    best_x_q, best_y_q, best_z_q;
  logic        [QW-1:0]    best_qx_q, best_qy_q, best_qz_q, best_qw_q;

  // Accumulator and square root
  logic [DIST_W-1:0] acc_q;
  logic [PW-1:0]     root_q;
  logic [IDX_W-1:0]  idx_q;

  // Output register
  logic                 out_valid_q;
  logic signed [PW-1:0] out_x_q, out_y_q, out_z_q;
  logic        [QW-1:0] out_qx_q, out_qy_q, out_qz_q, out_qw_q;
  logic        [PW-1:0] out_err_q;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign stat.in_valid  = cand_i.valid;
  assign stat.last      = last_q;
  assign stat.have_ref  = have_ref_q;
  assign stat.root_done = (idx_q == '0);
  assign stat.out_busy  = out_valid_q && !pose_o.ready;

  npt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  assign cand_i.ready = ctrl.in_ready;

  // ---------------------------------------------------------------------------
  // Distance magnitudes: one subtract per axis at acceptance
  // ---------------------------------------------------------------------------
  logic signed [MW-1:0] diff_x, diff_y, diff_z;

  assign diff_x = MW'(cand_i.pos_x) - MW'(ref_x_q);
  assign diff_y = MW'(cand_i.pos_y) - MW'(ref_y_q);
  assign diff_z = MW'(cand_i.pos_z) - MW'(ref_z_q);

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      pos_x_q  <= cand_i.pos_x;
      pos_y_q  <= cand_i.pos_y;
      pos_z_q  <= cand_i.pos_z;
      quat_x_q <= cand_i.quat_x;
      quat_y_q <= cand_i.quat_y;
      quat_z_q <= cand_i.quat_z;
      quat_w_q <= cand_i.quat_w;
      last_q   <= cand_i.last_candidate;
      // a magnitude of 2^PW is still exact as an unsigned MW-bit value
      dx_q     <= diff_x[MW-1] ? MW'(-diff_x) : MW'(diff_x);
      dy_q     <= diff_y[MW-1] ? MW'(-diff_y) : MW'(diff_y);
      dz_q     <= diff_z[MW-1] ? MW'(-diff_z) : MW'(diff_z);
    end
  end

  // ---------------------------------------------------------------------------
  // Shared squaring unit and its operand select
  // ---------------------------------------------------------------------------
  logic [MW-1:0]   mul_a;
  logic [2*MW-1:0] prod;
  logic [PW-1:0]   abs_bx, abs_by;
  logic [PW-1:0]   trial;

  assign abs_bx = best_x_q[PW-1] ? PW'(-best_x_q) : PW'(best_x_q);
  assign abs_by = best_y_q[PW-1] ? PW'(-best_y_q) : PW'(best_y_q);
  assign trial  = root_q | (PW'(1) << idx_q);

  always_comb begin
    unique case (ctrl.mul_src)
      MUL_DX:   mul_a = dx_q;
      MUL_DY:   mul_a = dy_q;
      MUL_DZ:   mul_a = dz_q;
      MUL_BX:   mul_a = MW'(abs_bx);
      MUL_BY:   mul_a = MW'(abs_by);
      MUL_ROOT: mul_a = MW'(trial);
      default:  mul_a = dx_q;
    endcase
  end

  npt_square #(
    .W (MW)
  ) u_square (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .sq_o  (prod)
  );

  // ---------------------------------------------------------------------------
  // Accumulator: sums squares for the distance and for the planar radius
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    unique case (ctrl.acc_op)
      ACC_LOAD: acc_q <= DIST_W'(prod);
      ACC_ADD:  acc_q <= acc_q + DIST_W'(prod);
      default:  acc_q <= acc_q;
    endcase
  end

  // Distance saturates at all ones beyond 64 bits (only for PW above 30)
  logic [SAT_W-1:0] dist_sat;
  logic             take;

  assign dist_sat = ((acc_q >> SAT_W) != '0) ? '1 : acc_q[SAT_W-1:0];
  assign take     = !mid_run_q || (have_ref_q && (dist_sat < best_dist_q));

  // ---------------------------------------------------------------------------
  // Best candidate of the run
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (ctrl.pick && take) begin
      best_dist_q <= dist_sat;
      best_x_q    <= pos_x_q;
      best_y_q    <= pos_y_q;
      best_z_q    <= pos_z_q;
      best_qx_q   <= quat_x_q;
      best_qy_q   <= quat_y_q;
      best_qz_q   <= quat_z_q;
      best_qw_q   <= quat_w_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Square root: set one bit from the top, keep it where trial^2 <= radius^2
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (ctrl.root_init) begin
      root_q <= '0;
      idx_q  <= IDX_W'(PW - 1);
    end else if (ctrl.root_step) begin
      if (DIST_W'(prod) <= acc_q) begin
        root_q <= trial;
      end
      idx_q <= idx_q - IDX_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Run state and reference pose
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_run_q  <= 1'b0;
      have_ref_q <= 1'b0;
      ref_x_q    <= '0;
      ref_y_q    <= '0;
      ref_z_q    <= '0;
    end else begin
      if (ctrl.pick) begin
        mid_run_q <= !last_q;
      end
      if (ctrl.emit) begin
        have_ref_q <= 1'b1;
        ref_x_q    <= best_x_q;
        ref_y_q    <= best_y_q;
        ref_z_q    <= best_z_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold the beat until taken
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (pose_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      out_x_q   <= best_x_q;
      out_y_q   <= best_y_q;
      out_z_q   <= best_z_q;
      out_qx_q  <= best_qx_q;
      out_qy_q  <= best_qy_q;
      out_qz_q  <= best_qz_q;
      out_qw_q  <= best_qw_q;
      // no reference yet: the first run reports zero error
      out_err_q <= have_ref_q ? root_q : '0;
    end
  end

  assign pose_o.valid        = out_valid_q;
  assign pose_o.out_x        = out_x_q;
  assign pose_o.out_y        = out_y_q;
  assign pose_o.out_z        = out_z_q;
  assign pose_o.out_quat_x   = out_qx_q;
  assign pose_o.out_quat_y   = out_qy_q;
  assign pose_o.out_quat_z   = out_qz_q;
  assign pose_o.out_quat_w   = out_qw_q;
  assign pose_o.planar_error = out_err_q;

endmodule

`default_nettype wire
